/* src/sha1_pkg.sv */
// shared types and constants for the sha-1 hash engine
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;

	// one queued input word
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} back_state_t;

	localparam int DIGEST_WORDS = 5;
	localparam int ROUNDS = 80;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_FILL = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd4;
	localparam logic [2:0] LAST_LEN  = 3'd7;

endpackage
`default_nettype wire

/* src/sha1_front.sv */
// input side: accepts words, drops empty ones, queues the rest
`timescale 1ns / 1ps
`default_nettype none
module sha1_front #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // msg_byte
	input  wire logic              s_tuser,  // byte_present
	input  wire logic              s_tlast,  // msg_end
	output sha1_pkg::qhead_t       head,
	input  wire logic              pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sha1_pkg::item_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              keep;
	logic              push;

	// a word with neither a byte nor an end changes nothing
	assign keep     = s_tuser | s_tlast;
	assign s_tready = (cnt_q != CNT_W'(DEPTH));
	assign push     = s_tvalid && s_tready && keep;

	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].data    <= s_tdata;
			slot_q[wr_ptr_q].present <= s_tuser;
			slot_q[wr_ptr_q].last    <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");

	a_drop_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !keep && !pop) |=> $stable(cnt_q))
		else $error("empty word took a queue slot");

endmodule
`default_nettype wire

/* src/sha1_back.sv */
// back end: block shift line, padding, 80-round compression, digest output
`timescale 1ns / 1ps
`default_nettype none
module sha1_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha1_pkg::qhead_t   head,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [39:0]             m_tdata,  // digest_word, word_number, zero fill
	output logic                    m_tlast   // digest_done
);

	sha1_pkg::back_state_t state_q, state_d;

	logic [511:0] blk_q;       // 64 message bytes, oldest in the top byte
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [31:0]  h_q [sha1_pkg::DIGEST_WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   round_q;
	logic         pad_q;       // padding still owed for this message
	logic         sent80_q;
	logic         len_q;
	logic [2:0]   len_cnt_q;
	logic         fin_q;       // last block in flight
	logic [2:0]   out_idx_q;

	logic         shift_en;
	logic [7:0]   shift_byte;
	logic         len_byte;
	logic [7:0]   pad_byte;
	logic         blk_full;
	logic         out_fire;
	logic [31:0]  f_val;
	logic [31:0]  k_val;
	logic [31:0]  t_val;
	logic [31:0]  w_new;

	// length bytes start once 0x80 is in and the block reaches byte 56
	assign len_byte = sent80_q && (len_q || (fill_q == sha1_pkg::LEN_POS));

	always_comb begin
		priority if (!sent80_q) begin
			pad_byte = sha1_pkg::PAD_BYTE;
		end else if (len_byte) begin
			pad_byte = bits_q[{~len_cnt_q, 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// outputs of the sequencer
	always_comb begin
		pop        = 1'b0;
		shift_en   = 1'b0;
		shift_byte = head.item.data;
		m_tvalid   = 1'b0;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				pop      = head.valid;
				shift_en = head.valid && head.item.present;
			end
			sha1_pkg::ST_PAD: begin
				shift_en   = 1'b1;
				shift_byte = pad_byte;
			end
			sha1_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign blk_full = shift_en && (fill_q == sha1_pkg::LAST_FILL);
	assign out_fire = m_tvalid && m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (pop) begin
					if (blk_full) begin
						state_d = sha1_pkg::ST_COMP;
					end else if (head.item.last) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (blk_full) begin
					state_d = sha1_pkg::ST_COMP;
				end
			end
			sha1_pkg::ST_COMP: begin
				if (round_q == 7'(sha1_pkg::ROUNDS - 1)) begin
					state_d = sha1_pkg::ST_FIN;
				end
			end
			sha1_pkg::ST_FIN: begin
				priority if (fin_q) begin
					state_d = sha1_pkg::ST_OUT;
				end else if (pad_q) begin
					state_d = sha1_pkg::ST_PAD;
				end else begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			sha1_pkg::ST_OUT: begin
				if (out_fire && (out_idx_q == sha1_pkg::LAST_WORD)) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	// round function
	always_comb begin
		priority if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1_pkg::K_R0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K_R1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1_pkg::K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + blk_q[511:480];

	// schedule word for t+16 from the taps at t, t+2, t+8 and t+13
	always_comb begin
		logic [31:0] x;
		x     = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
		w_new = {x[30:0], x[31]};
	end

	assign m_tdata = {5'b00000, out_idx_q, h_q[out_idx_q]};
	assign m_tlast = (out_idx_q == sha1_pkg::LAST_WORD);

	// datapath without reset
	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == sha1_pkg::ST_COMP) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (blk_full) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == sha1_pkg::ST_COMP) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha1_pkg::ST_IDLE;
			fill_q    <= '0;
			bits_q    <= '0;
			h_q       <= sha1_pkg::H_INIT;
			round_q   <= '0;
			pad_q     <= 1'b0;
			sent80_q  <= 1'b0;
			len_q     <= 1'b0;
			len_cnt_q <= '0;
			fin_q     <= 1'b0;
			out_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == sha1_pkg::ST_IDLE && pop) begin
				if (head.item.present) begin
					bits_q <= bits_q + 64'd8;
				end
				if (head.item.last) begin
					pad_q <= 1'b1;
				end
			end
			if (state_q == sha1_pkg::ST_PAD) begin
				if (!sent80_q) begin
					sent80_q <= 1'b1;
				end else if (len_byte) begin
					len_q     <= 1'b1;
					len_cnt_q <= len_cnt_q + 1'b1;
					if (len_cnt_q == sha1_pkg::LAST_LEN) begin
						fin_q <= 1'b1;
					end
				end
			end
			if (blk_full) begin
				round_q <= '0;
			end else if (state_q == sha1_pkg::ST_COMP) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == sha1_pkg::ST_FIN) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (out_fire) begin
				if (out_idx_q == sha1_pkg::LAST_WORD) begin
					// back to the initial state for the next message
					out_idx_q <= '0;
					h_q       <= sha1_pkg::H_INIT;
					fill_q    <= '0;
					bits_q    <= '0;
					pad_q     <= 1'b0;
					sent80_q  <= 1'b0;
					len_q     <= 1'b0;
					len_cnt_q <= '0;
					fin_q     <= 1'b0;
				end else begin
					out_idx_q <= out_idx_q + 1'b1;
				end
			end
		end
	end

	a_comp_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_COMP && round_q == 7'(sha1_pkg::ROUNDS - 1))
		|=> state_q == sha1_pkg::ST_FIN)
		else $error("compression did not end after the last round");

	a_out_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_OUT) |-> (fill_q == '0 && fin_q))
		else $error("digest shown before the final block closed");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out_idx_q == sha1_pkg::LAST_WORD)
		|=> (fill_q == '0 && bits_q == '0 && !pad_q && out_idx_q == '0))
		else $error("state not restored after digest");

endmodule
`default_nettype wire

/* src/sha1_hash_engine_core.sv */
// top level of the sha-1 hash engine
`timescale 1ns / 1ps
`default_nettype none
// SHA-1 hasher taking one message byte per word and giving the 160-bit digest as five
// 32-bit words, H0 first, with tlast on the fifth. A word with tuser high carries a
// byte; a word with tlast high ends the message (with or without a byte, so an empty
// message works); a word with neither is dropped. Bytes enter a queue of QUEUE_DEPTH
// words and are taken by the back end at one per cycle while it is idle. Each time 64
// bytes are held the back end compresses the block (80 rounds of one shared round unit
// and then a fold into the chaining words), during which the queue fills and then
// stalls the input. An end word makes the back end shift in the padding bytes (9 to
// 72 bytes), run one or two block compressions, and then show the five digest words.
// No new bytes are taken while padding, compressing or showing the digest.
module sha1_hash_engine_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
	input  wire logic        s_axis_tuser,   // [0] byte_present
	input  wire logic        s_axis_tlast,   // msg_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_number
	output logic             m_axis_tlast    // digest_done
);

	sha1_pkg::qhead_t head;
	logic             pop;

	sha1_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.s_tlast  (s_axis_tlast),
		.head     (head),
		.pop      (pop)
	);

	sha1_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the sha-1 hash engine with a built-in digest predictor
`timescale 1ns / 1ps
module testbench;

	localparam logic [31:0] SHA_K0 = 32'h5A827999;
	localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;
	localparam logic [31:0] SHA_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_SLOT = 6'd56;
	localparam int RANDOM_ITEMS = 380;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  index;
		logic        done;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// predicted engine state
	logic [31:0] chain [5];
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic [63:0] msg_bits;

	sha1_pkg::item_t byte_stream [$];
	digest_word_t    pending_digest_words [$];
	int              words_total;
	int              words_sent = 0;
	int              err_count = 0;
	int              src_gap = 0;
	int              src_calm = 0;
	int              sink_stall = 0;
	int              sink_calm = 0;

	sha1_hash_engine_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] msg_byte
		.s_axis_tuser  (s_axis_tuser),   // [0] byte_present
		.s_axis_tlast  (s_axis_tlast),   // msg_end
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [31:0] digest_word, [34:32] word_number
		.m_axis_tlast  (m_axis_tlast)    // digest_done
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
		for (int r = 16; r < 80; r++)
			w[r] = rol(w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16], 1);
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = SHA_K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = SHA_K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = SHA_K2;
			end else begin
				f = b ^ c ^ d;
				k = SHA_K3;
			end
			t = rol(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void push_byte(input logic [7:0] v);
		blk[fill] = v;
		fill = fill + 6'd1;
		// six-bit count wraps to zero on a full block
		if (fill == 6'd0)
			compress_block();
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 5; i++)
			chain[i] = SHA_IV[i];
		fill = 6'd0;
		msg_bits = 64'd0;
	endfunction

	function automatic void hash_word_in(input sha1_pkg::item_t it);
		logic [63:0] len;
		digest_word_t dw;
		if (it.present) begin
			push_byte(it.data);
			msg_bits += 64'd8;
		end
		if (it.last) begin
			len = msg_bits;
			push_byte(PAD_MARK);
			while (fill != LEN_SLOT)
				push_byte(8'h00);
			for (int i = 0; i < 8; i++)
				push_byte(len[63 - 8 * i -: 8]);
			for (int i = 0; i < 5; i++) begin
				dw.value = chain[i];
				dw.index = 3'(i);
				dw.done = (i == 4);
				pending_digest_words.push_back(dw);
			end
			restart_hash();
		end
	endfunction

	// wait length for one word, with runs of back-to-back words now and then
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic sha1_pkg::item_t make_item(input logic [7:0] d, input logic p,
		input logic l);
		sha1_pkg::item_t it;
		it.data = d;
		it.present = p;
		it.last = l;
		return it;
	endfunction

	task automatic queue_message(input int len, input bit bare_end);
		for (int i = 0; i < len; i++) begin
			// stray words with neither byte nor end
			if ($urandom_range(0, 15) == 0)
				byte_stream.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			byte_stream.push_back(make_item(8'($urandom_range(0, 255)), 1'b1,
				(i == len - 1) && !bare_end));
		end
		if (bare_end || len == 0)
			byte_stream.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		sha1_pkg::item_t ni;
		logic nv;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_word_in(make_item(s_axis_tdata, s_axis_tuser, s_axis_tlast));
				words_sent++;
				src_gap = draw_wait(src_calm);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				nv = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (byte_stream.size() > 0) begin
					ni = byte_stream.pop_front();
					nv = 1'b1;
					s_axis_tdata <= ni.data;
					s_axis_tuser <= ni.present;
					s_axis_tlast <= ni.last;
				end
				s_axis_tvalid <= nv;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		digest_word_t exp_w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_digest_words.size() == 0) begin
					$display("%0t unexpected digest word: expected none, got %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					err_count++;
				end else begin
					exp_w = pending_digest_words.pop_front();
					if (m_axis_tdata[31:0] !== exp_w.value) begin
						$display("%0t digest value: expected %h, got %h",
							$time, exp_w.value, m_axis_tdata[31:0]);
						err_count++;
					end
					if (m_axis_tdata[34:32] !== exp_w.index) begin
						$display("%0t word number: expected %0d, got %0d",
							$time, exp_w.index, m_axis_tdata[34:32]);
						err_count++;
					end
					if (m_axis_tlast !== exp_w.done) begin
						$display("%0t digest done: expected %b, got %b",
							$time, exp_w.done, m_axis_tlast);
						err_count++;
					end
				end
				sink_stall = draw_wait(sink_calm);
			end else if (m_axis_tvalid && sink_stall > 0) begin
				sink_stall--;
			end
			m_axis_tready <= (sink_stall == 0);
		end
	end

	initial begin
		int unsigned pick;
		int len;
		restart_hash();

		// empty message, then empty message behind a stray word
		byte_stream.push_back(make_item(8'h00, 1'b0, 1'b1));
		byte_stream.push_back(make_item(8'hFF, 1'b0, 1'b0));
		byte_stream.push_back(make_item(8'hFF, 1'b0, 1'b1));
		// single byte carried on the end word, both extremes
		byte_stream.push_back(make_item(8'h00, 1'b1, 1'b1));
		byte_stream.push_back(make_item(8'hFF, 1'b1, 1'b1));
		// "abc" closed by a bare end
		byte_stream.push_back(make_item(8'h61, 1'b1, 1'b0));
		byte_stream.push_back(make_item(8'h62, 1'b1, 1'b0));
		byte_stream.push_back(make_item(8'h63, 1'b1, 1'b0));
		byte_stream.push_back(make_item(8'hA5, 1'b0, 1'b1));
		// alternating bits, stray word inside, byte with end
		byte_stream.push_back(make_item(8'h55, 1'b1, 1'b0));
		byte_stream.push_back(make_item(8'h5A, 1'b0, 1'b0));
		byte_stream.push_back(make_item(8'hAA, 1'b1, 1'b1));
		// stray words between messages
		byte_stream.push_back(make_item(8'h00, 1'b0, 1'b0));
		byte_stream.push_back(make_item(8'hFF, 1'b0, 1'b0));

		while (byte_stream.size() < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				len = $urandom_range(0, 16);
			else if (pick < 7)
				len = $urandom_range(17, 70);
			else if (pick < 9) begin
				// lengths around the padding and block boundaries
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					4: len = 119;
					default: len = 120;
				endcase
			end else
				len = $urandom_range(100, 130);
			// keep the total close to the planned item count
			if (len > RANDOM_ITEMS - byte_stream.size())
				len = RANDOM_ITEMS - byte_stream.size();
			queue_message(len, 1'($urandom_range(0, 1)));
		end
		words_total = byte_stream.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (!(words_sent == words_total && pending_digest_words.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
